[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the sine oscillator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is active
`define PKTO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Assertion that holds on every edge, reset included
`define PKTO_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

[hw/rtl/pkto_pkg.sv]
// ----------------------------------------------------------------------------
// pkto_pkg
// Types, constants and helper functions shared by the sine oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package pkto_pkg;

  // Field widths
  localparam int unsigned FREQ_W  = 18;
  localparam int unsigned AMP_W   = 16;
  localparam int unsigned BLEN_W  = 7;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned IDX_W   = 2;

  // Divider sizes: widest dividend is remainder << 32, widest divisor 2*period
  localparam int unsigned DIV_W   = 50;
  localparam int unsigned DVS_W   = 19;
  localparam int unsigned DCNT_W  = 6;

  localparam logic [BLEN_W-1:0] MAX_BUFFER = 7'd64;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [IDX_W-1:0] REG_START_FREQ  = 2'd1;
  localparam logic [IDX_W-1:0] REG_AMPLITUDE   = 2'd2;
  localparam logic [IDX_W-1:0] REG_BUFFER_LEN  = 2'd3;

  // Reset values
  localparam logic [FREQ_W-1:0] RST_SAMPLE_RATE = 18'd44100;
  localparam logic [FREQ_W-1:0] RST_START_FREQ  = 18'd1000;
  localparam logic [AMP_W-1:0]  RST_AMPLITUDE   = 16'd32768;
  localparam logic [BLEN_W-1:0] RST_BUFFER_LEN  = 7'd64;
  localparam logic [FREQ_W-1:0] RST_PERIOD      = 18'd44;

  // Fixed point constants
  localparam logic [30:0] Q30_ONE    = 31'd1073741824;
  localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
  localparam logic [15:0] SMP_MAX    = 16'd32767;
  localparam int unsigned TAYLOR_STEPS = 6;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_CFG, OP_ACCEPT, OP_NP_START, OP_NP_WAIT, OP_MUL_POSNP,
    OP_ND_START, OP_ND_WAIT, OP_SET, OP_WRAP, OP_MUL_CFPOS, OP_MOD_START,
    OP_MOD_WAIT, OP_PH_START, OP_PH_WAIT, OP_MUL_UH, OP_X, OP_MUL_XX, OP_X2,
    OP_MUL_X2T, OP_MUL_RCP, OP_TD, OP_MUL_XT, OP_S, OP_MUL_SA, OP_G2,
    OP_MAG, OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic nf_nz;
    logic np_skip;
    logic pl_zero;
    logic cnt_zero;
    logic k_last;
    logic cnt_last;
    logic out_free;
  } sts_t;

  // Taylor series divisors 156, 110, 72, 42, 20, 6 (innermost term first),
  // each split as 2^a * o: floor(y / d) = ((y >> a) * ceil(2^s / o)) >> s,
  // exact for every y below 2^32.
  function automatic logic [1:0] taylor_pre(input logic [2:0] k);
    logic [1:0] a;
    case (k)
      3'd0:    a = 2'd2;
      3'd1:    a = 2'd1;
      3'd2:    a = 2'd3;
      3'd3:    a = 2'd1;
      3'd4:    a = 2'd2;
      default: a = 2'd1;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] taylor_rcp(input logic [2:0] k);
    logic [31:0] m;
    case (k)
      3'd0:    m = 32'd3524075731;
      3'd1:    m = 32'd2498890064;
      3'd2:    m = 32'd3817748708;
      3'd3:    m = 32'd3272356036;
      3'd4:    m = 32'd3435973837;
      default: m = 32'd2863311531;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] taylor_sh(input logic [2:0] k);
    logic [5:0] s;
    case (k)
      3'd0:    s = 6'd37;
      3'd1:    s = 6'd37;
      3'd2:    s = 6'd35;
      3'd3:    s = 6'd36;
      3'd4:    s = 6'd34;
      default: s = 6'd33;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pkto_div.sv]
// ----------------------------------------------------------------------------
// pkto_div
// Restoring divider, one quotient bit per cycle, variable dividend length.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pkto_div import pkto_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DVS_W-1:0]  divisor_i,
  input  logic [DCNT_W-1:0] nbits_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quotient_o,
  output logic [DVS_W-1:0]  remainder_o
);

  localparam logic [DCNT_W-1:0] DIV_BITS = DCNT_W'(DIV_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  sh_q, sh_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    trial;
  logic              qbit;

  // One trial subtraction per cycle
  always_comb begin
    trial  = {rem_q, sh_q[DIV_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = nbits_i;
      rem_d  = '0;
      sh_d   = dividend_i << (DIV_BITS - nbits_i);
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      sh_d  = {sh_q[DIV_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = sh_q;
  assign remainder_o = rem_q;

  `PKTO_ASSERT_CLK(a_div_done_idle, clk_i, done_q |-> !busy_q)

endmodule

`default_nettype wire

[hw/rtl/pkto_dp.sv]
// ----------------------------------------------------------------------------
// pkto_dp
// Datapath: registers, shared multiplier, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pkto_dp import pkto_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [FREQ_W-1:0]  cfg_data_i,
  input  logic [FREQ_W-1:0]  in_new_frequency_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [SMP_W-1:0] out_sample_o,
  output logic               out_last_o
);

  // Configuration and oscillator state
  logic [FREQ_W-1:0] sr_q, pos_q, pl_q, cf_q;
  logic [AMP_W-1:0]  amp_q;
  logic [BLEN_W-1:0] blen_q;

  // Working registers
  logic [FREQ_W-1:0] np_q, npos_q, r_q;
  logic [63:0]       mul_q;
  logic [1:0]        quad_q;
  logic [30:0]       u_q, x_q, t_q, s_q;
  logic [31:0]       x2_q;
  logic [2:0]        k_q;
  logic [61:0]       g_q;
  logic [SMP_W-1:0]  smp_q;
  logic [BLEN_W-1:0] cnt_q;

  // Output register
  logic              ovld_q;
  logic [SMP_W-1:0]  osmp_q;
  logic              olast_q;

  logic [BLEN_W-1:0] cnt_max;
  logic              out_free;
  logic              mul_en;
  logic [31:0]       mul_a, mul_b;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_a, div_q;
  logic [DVS_W-1:0]  div_b, div_r;
  logic [DCNT_W-1:0] div_n;
  logic [32:0]       td_d;
  logic [16:0]       mag17;
  logic [SMP_W-1:0]  mag16;

  assign cnt_max  = (blen_q > MAX_BUFFER) ? MAX_BUFFER : blen_q;
  assign out_free = !ovld_q || !out_stall_i;
  // Taylor quotient from the reciprocal product
  assign td_d     = 33'(mul_q >> taylor_sh(k_q));
  assign mag17    = g_q[61:45];
  assign mag16    = (mag17 > 17'(SMP_MAX)) ? SMP_MAX : mag17[SMP_W-1:0];

  // Status to the controller
  always_comb begin
    sts_o.div_done = div_done;
    sts_o.nf_nz    = (in_new_frequency_i != '0);
    sts_o.np_skip  = (cf_q == '0) || (sr_q == '0);
    sts_o.pl_zero  = (pl_q == '0);
    sts_o.cnt_zero = (blen_q == '0);
    sts_o.k_last   = (k_q == 3'(TAYLOR_STEPS - 1));
    sts_o.cnt_last = ((cnt_q + 1'b1) == cnt_max);
    sts_o.out_free = out_free;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd_i.op)
      OP_MUL_POSNP: begin mul_a = 32'(pos_q);        mul_b = 32'(np_q);   end
      OP_MUL_CFPOS: begin mul_a = 32'(cf_q);         mul_b = 32'(pos_q);  end
      OP_MUL_UH:    begin mul_a = 32'(u_q);          mul_b = HALFPI_Q30;  end
      OP_MUL_XX:    begin mul_a = 32'(x_q);          mul_b = 32'(x_q);    end
      OP_MUL_X2T:   begin mul_a = x2_q;              mul_b = 32'(t_q);    end
      OP_MUL_RCP: begin
        mul_a = mul_q[61:30] >> taylor_pre(k_q);
        mul_b = taylor_rcp(k_q);
      end
      OP_MUL_XT:    begin mul_a = 32'(x_q);          mul_b = 32'(t_q);    end
      OP_MUL_SA:    begin mul_a = 32'(s_q);          mul_b = 32'(amp_q);  end
      default:      mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    div_n     = '0;
    case (cmd_i.op)
      OP_NP_START: begin
        div_start = !sts_o.np_skip;
        div_a     = DIV_W'(sr_q);
        div_b     = DVS_W'(cf_q);
        div_n     = DCNT_W'(FREQ_W);
      end
      OP_ND_START: begin
        div_start = (pl_q != '0);
        div_a     = DIV_W'({mul_q[35:0], 1'b0}) + DIV_W'(pl_q);
        div_b     = {pl_q, 1'b0};
        div_n     = DCNT_W'(38);
      end
      OP_MOD_START: begin
        div_start = 1'b1;
        div_a     = DIV_W'(mul_q[35:0]);
        div_b     = DVS_W'(sr_q);
        div_n     = DCNT_W'(36);
      end
      OP_PH_START: begin
        div_start = 1'b1;
        div_a     = {r_q, 32'd0};
        div_b     = DVS_W'(sr_q);
        div_n     = DCNT_W'(DIV_W);
      end
      default: ;
    endcase
  end

  pkto_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .nbits_i     (div_n),
    .done_o      (div_done),
    .quotient_o  (div_q),
    .remainder_o (div_r)
  );

  // Configuration, oscillator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q    <= RST_SAMPLE_RATE;
      amp_q   <= RST_AMPLITUDE;
      blen_q  <= RST_BUFFER_LEN;
      cf_q    <= RST_START_FREQ;
      pl_q    <= RST_PERIOD;
      pos_q   <= '0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CFG: begin
          case (cfg_index_i)
            REG_SAMPLE_RATE: sr_q <= cfg_data_i;
            REG_START_FREQ:  cf_q <= cfg_data_i;
            REG_AMPLITUDE:   amp_q  <= cfg_data_i[AMP_W-1:0];
            REG_BUFFER_LEN:  blen_q <= cfg_data_i[BLEN_W-1:0];
            default: ;
          endcase
        end
        OP_ACCEPT: begin
          cnt_q <= '0;
          if (sts_o.nf_nz) begin
            cf_q <= in_new_frequency_i;
          end
        end
        OP_SET: begin
          pl_q  <= np_q;
          pos_q <= npos_q;
        end
        OP_WRAP: begin
          if (pos_q >= pl_q) begin
            pos_q <= '0;
          end
        end
        OP_OUT: begin
          if (out_free) begin
            ovld_q <= 1'b1;
            pos_q  <= pos_q + 1'b1;
            cnt_q  <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_NP_START: if (sts_o.np_skip) np_q <= '0;
      OP_NP_WAIT:  if (div_done) np_q <= div_q[FREQ_W-1:0];
      OP_ND_START: if (pl_q == '0) npos_q <= '0;
      OP_ND_WAIT:  if (div_done) npos_q <= div_q[FREQ_W-1:0];
      OP_MOD_WAIT: if (div_done) r_q <= div_r[FREQ_W-1:0];
      OP_PH_WAIT: begin
        if (div_done) begin
          quad_q <= div_q[31:30];
          u_q    <= div_q[30] ? (Q30_ONE - {1'b0, div_q[29:0]}) : {1'b0, div_q[29:0]};
        end
      end
      OP_X:  x_q <= mul_q[60:30];
      OP_X2: begin
        x2_q <= mul_q[61:30];
        t_q  <= Q30_ONE;
        k_q  <= '0;
      end
      OP_TD: begin
        t_q <= (td_d >= 33'(Q30_ONE)) ? '0 : 31'(33'(Q30_ONE) - td_d);
        k_q <= k_q + 1'b1;
      end
      OP_S:   s_q <= mul_q[60:30];
      OP_G2:  g_q <= {mul_q[46:0], 15'd0} - 62'(mul_q[46:0]);
      OP_MAG: smp_q <= quad_q[1] ? (SMP_W'(0) - mag16) : mag16;
      OP_OUT: begin
        if (out_free) begin
          osmp_q  <= smp_q;
          olast_q <= sts_o.cnt_last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = ovld_q;
  assign out_sample_o = osmp_q;
  assign out_last_o   = olast_q;

  `PKTO_ASSERT(a_dp_wrap_in_period, clk_i, rst_ni,
               (cmd_i.op == OP_WRAP) |=> (pos_q < pl_q))
  `PKTO_ASSERT(a_dp_out_needs_slot, clk_i, rst_ni,
               (cmd_i.op == OP_OUT && !out_free) |=> $stable(cnt_q))

endmodule

`default_nettype wire

[hw/rtl/pkto_ctrl.sv]
// ----------------------------------------------------------------------------
// pkto_ctrl
// Controller: sequences rebuilds and per-sample sine evaluation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pkto_ctrl import pkto_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned ST_W = 27;

  typedef enum logic [ST_W-1:0] {
    ST_IDLE    = ST_W'(1) << 0,
    ST_RB_NP   = ST_W'(1) << 1,
    ST_RB_NPW  = ST_W'(1) << 2,
    ST_RB_MUL  = ST_W'(1) << 3,
    ST_RB_ND   = ST_W'(1) << 4,
    ST_RB_NDW  = ST_W'(1) << 5,
    ST_RB_SET  = ST_W'(1) << 6,
    ST_IT_CHK  = ST_W'(1) << 7,
    ST_SM_CHK  = ST_W'(1) << 8,
    ST_SM_MUL  = ST_W'(1) << 9,
    ST_SM_MOD  = ST_W'(1) << 10,
    ST_SM_MODW = ST_W'(1) << 11,
    ST_SM_PH   = ST_W'(1) << 12,
    ST_SM_PHW  = ST_W'(1) << 13,
    ST_SM_XM   = ST_W'(1) << 14,
    ST_SM_X    = ST_W'(1) << 15,
    ST_SM_X2M  = ST_W'(1) << 16,
    ST_SM_X2   = ST_W'(1) << 17,
    ST_SM_TM   = ST_W'(1) << 18,
    ST_SM_TD   = ST_W'(1) << 19,
    ST_SM_TDW  = ST_W'(1) << 20,
    ST_SM_SM   = ST_W'(1) << 21,
    ST_SM_S    = ST_W'(1) << 22,
    ST_SM_GM   = ST_W'(1) << 23,
    ST_SM_G2   = ST_W'(1) << 24,
    ST_SM_MAG  = ST_W'(1) << 25,
    ST_SM_OUT  = ST_W'(1) << 26
  } state_e;

  state_e state_q, state_d;
  logic   item_q, item_d;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;

  // Next state and command
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.op = OP_CFG;
          item_d   = 1'b0;
          state_d  = ST_RB_NP;
        end else if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          item_d   = 1'b1;
          state_d  = sts_i.nf_nz ? ST_RB_NP : ST_IT_CHK;
        end
      end
      // Rebuild: new period, then rescaled position
      ST_RB_NP: begin
        cmd_o.op = OP_NP_START;
        state_d  = sts_i.np_skip ? ST_RB_MUL : ST_RB_NPW;
      end
      ST_RB_NPW: begin
        cmd_o.op = OP_NP_WAIT;
        if (sts_i.div_done) state_d = ST_RB_MUL;
      end
      ST_RB_MUL: begin
        cmd_o.op = OP_MUL_POSNP;
        state_d  = ST_RB_ND;
      end
      ST_RB_ND: begin
        cmd_o.op = OP_ND_START;
        state_d  = sts_i.pl_zero ? ST_RB_SET : ST_RB_NDW;
      end
      ST_RB_NDW: begin
        cmd_o.op = OP_ND_WAIT;
        if (sts_i.div_done) state_d = ST_RB_SET;
      end
      ST_RB_SET: begin
        cmd_o.op = OP_SET;
        state_d  = item_q ? ST_IT_CHK : ST_IDLE;
      end
      ST_IT_CHK: begin
        state_d = (sts_i.pl_zero || sts_i.cnt_zero) ? ST_IDLE : ST_SM_CHK;
      end
      // Per-sample phase and sine evaluation
      ST_SM_CHK: begin cmd_o.op = OP_WRAP;      state_d = ST_SM_MUL; end
      ST_SM_MUL: begin cmd_o.op = OP_MUL_CFPOS; state_d = ST_SM_MOD; end
      ST_SM_MOD: begin cmd_o.op = OP_MOD_START; state_d = ST_SM_MODW; end
      ST_SM_MODW: begin
        cmd_o.op = OP_MOD_WAIT;
        if (sts_i.div_done) state_d = ST_SM_PH;
      end
      ST_SM_PH: begin cmd_o.op = OP_PH_START; state_d = ST_SM_PHW; end
      ST_SM_PHW: begin
        cmd_o.op = OP_PH_WAIT;
        if (sts_i.div_done) state_d = ST_SM_XM;
      end
      ST_SM_XM:  begin cmd_o.op = OP_MUL_UH;  state_d = ST_SM_X;   end
      ST_SM_X:   begin cmd_o.op = OP_X;       state_d = ST_SM_X2M; end
      ST_SM_X2M: begin cmd_o.op = OP_MUL_XX;  state_d = ST_SM_X2;  end
      ST_SM_X2:  begin cmd_o.op = OP_X2;      state_d = ST_SM_TM;  end
      ST_SM_TM:  begin cmd_o.op = OP_MUL_X2T; state_d = ST_SM_TD;  end
      ST_SM_TD:  begin cmd_o.op = OP_MUL_RCP; state_d = ST_SM_TDW; end
      ST_SM_TDW: begin
        cmd_o.op = OP_TD;
        state_d  = sts_i.k_last ? ST_SM_SM : ST_SM_TM;
      end
      ST_SM_SM:  begin cmd_o.op = OP_MUL_XT; state_d = ST_SM_S;   end
      ST_SM_S:   begin cmd_o.op = OP_S;      state_d = ST_SM_GM;  end
      ST_SM_GM:  begin cmd_o.op = OP_MUL_SA; state_d = ST_SM_G2;  end
      ST_SM_G2:  begin cmd_o.op = OP_G2;     state_d = ST_SM_MAG; end
      ST_SM_MAG: begin cmd_o.op = OP_MAG;    state_d = ST_SM_OUT; end
      ST_SM_OUT: begin
        cmd_o.op = OP_OUT;
        if (sts_i.out_free) state_d = sts_i.cnt_last ? ST_IDLE : ST_SM_CHK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      item_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
    end
  end

  `PKTO_ASSERT(a_ctrl_cfg_blocks_item, clk_i, rst_ni,
               (cfg_valid_i && cfg_ready_o) |-> in_stall_o)
  `PKTO_ASSERT(a_ctrl_accept_leaves_idle, clk_i, rst_ni,
               (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))

endmodule

`default_nettype wire

[hw/rtl/phase_kept_sine_table_oscillator.sv]
// ----------------------------------------------------------------------------
// phase_kept_sine_table_oscillator
// Whole-hertz sine oscillator that plays buffers of Q1.15-scaled samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): each transaction asks for one
//   buffer of buffer_length samples (capped at 64); a nonzero
//   in_new_frequency_i retunes first, rescaling the playback position.
//   Output channel (out_valid_o / out_stall_i): one transaction per sample,
//   out_last_o marks the final sample of the buffer. No samples come out
//   while the period length is zero.
//   Config channel (cfg_valid_i / cfg_ready_o): register writes while idle;
//   each write retunes the same way a new frequency does.
//   Sequencing: one item at a time. Each sample runs the shared
//   one-bit-per-cycle divider twice (phase modulo, then phase fraction);
//   the six Taylor terms each go through reciprocal multiplication. A
//   retune also uses the divider, for the new period and rescaled position.
//   Reset: registers return to 44100 Hz rate, 1000 Hz tone, unity gain,
//   64-sample buffers; period 44, position 0; no result pending.
//   Receiver stall: the finished sample waits in the output register while
//   the next one is computed; work halts only when a second one is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_kept_sine_table_oscillator import pkto_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FREQ_W-1:0]       in_new_frequency_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SMP_W-1:0] out_sample_o,
  output logic                    out_last_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IDX_W-1:0]        cfg_index_i,
  input  logic [FREQ_W-1:0]       cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  pkto_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pkto_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_new_frequency_i (in_new_frequency_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_sample_o       (out_sample_o),
    .out_last_o         (out_last_o)
  );

endmodule

`default_nettype wire
